FILE: sv/crt_pkg.sv
// Shared types and constants for the Catmull-Rom curve tessellator.
// No dependencies.
`default_nettype none
package crt_pkg;
  localparam int OUT_W = 28;
  localparam int DETAIL_W = 7;
  localparam int DETAIL_MAX = 64;
  localparam logic [DETAIL_W-1:0] DETAIL_RESET = 7'd50;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TDIV, ST_EVAL, ST_OUT
  } state_t;

  typedef struct packed {
    logic load_seg;
    logic end_seg;
    logic start_div;
    logic start_eval;
    logic next_sample;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic eval_done;
    logic last_sample;
  } sts_t;
endpackage
`default_nettype wire

FILE: sv/crt_ctrl.sv
// Controller state machine for the tessellator.
// Depends on crt_pkg.
`default_nettype none
module crt_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic in_kind,
  input  wire logic [1:0] seen,
  input  wire logic out_free,
  input  wire crt_pkg::sts_t sts,
  output crt_pkg::cmd_t cmd,
  output logic busy,
  output logic out_load
);
  import crt_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_load = 1'b0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && seen >= 2'd2) begin
          cmd.load_seg = 1'b1;
          cmd.end_seg = (in_kind == KIND_END);
          cmd.start_div = 1'b1;
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (sts.div_done) begin
          cmd.start_eval = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.eval_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (sts.last_sample) state_nxt = ST_IDLE;
          else begin
            cmd.next_sample = 1'b1;
            cmd.start_div = 1'b1;
            state_nxt = ST_TDIV;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/crt_datapath.sv
// Datapath: vertex window, coefficients, t divider and shared Horner unit.
// Depends on crt_pkg.
`default_nettype none
module crt_datapath #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic in_kind,
  input  wire logic signed [COORD_WIDTH-1:0] in_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_y,
  input  wire logic [crt_pkg::DETAIL_W-1:0] detail,
  input  wire crt_pkg::cmd_t cmd,
  output crt_pkg::sts_t sts,
  output logic [1:0] seen,
  output logic signed [crt_pkg::OUT_W-1:0] res [4],
  output logic res_last
);
  import crt_pkg::*;
  localparam int CW = COORD_WIDTH + 4;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int HW = CW + T_FRAC_BITS + 4;
  localparam int NW = T_FRAC_BITS + 8;
  localparam int SH = T_FRAC_BITS - 7;

  logic signed [COORD_WIDTH-1:0] wx_r [3], wy_r [3];
  logic [1:0] seen_r;
  logic signed [CW-1:0] a_r [2][4];
  logic [6:0] n_r, c_r;
  logic [TW-1:0] t_r [2];
  logic [NW-1:0] num_r;
  logic [TW-1:0] q_r;
  logic [4:0] dcnt_r;
  logic dbusy_r, ddone_r, tsel_r;
  logic signed [HW-1:0] h_r;
  logic [1:0] k_r;
  logic [1:0] pidx_r;
  logic ebusy_r, edone_r;

  assign seen = seen_r;

  function automatic logic signed [CW-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
    return CW'(v);
  endfunction

  logic [6:0] n_clip;
  always_comb begin
    n_clip = detail;
    if (detail == '0) n_clip = 7'd1;
    else if (detail > 7'(DETAIL_MAX)) n_clip = 7'(DETAIL_MAX);
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] p [2][4];
    logic b;
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < 3; i++) begin wx_r[i] <= '0; wy_r[i] <= '0; end
    end else if (in_fire) begin
      b = (seen_r == 2'd3);
      p[0][0] = sx(wx_r[0]); p[1][0] = sx(wy_r[0]);
      p[0][1] = b ? sx(wx_r[1]) : sx(wx_r[0]);
      p[1][1] = b ? sx(wy_r[1]) : sx(wy_r[0]);
      p[0][2] = b ? sx(wx_r[2]) : sx(wx_r[1]);
      p[1][2] = b ? sx(wy_r[2]) : sx(wy_r[1]);
      if (in_kind == KIND_END) begin
        p[0][3] = CW'(2 * p[0][2] - p[0][1]);
        p[1][3] = CW'(2 * p[1][2] - p[1][1]);
      end else begin
        p[0][3] = sx(in_x); p[1][3] = sx(in_y);
      end
      if (cmd.load_seg) begin
        for (int d = 0; d < 2; d++) begin
          a_r[d][0] <= CW'(2 * p[d][1]);
          a_r[d][1] <= CW'(p[d][2] - p[d][0]);
          a_r[d][2] <= CW'(2 * p[d][0] - 5 * p[d][1] + 4 * p[d][2] - p[d][3]);
          a_r[d][3] <= CW'(-p[d][0] + 3 * p[d][1] - 3 * p[d][2] + p[d][3]);
        end
      end
      if (in_kind == KIND_END) begin
        seen_r <= '0;
        for (int i = 0; i < 3; i++) begin wx_r[i] <= '0; wy_r[i] <= '0; end
      end else if (seen_r < 2'd3) begin
        wx_r[seen_r] <= in_x; wy_r[seen_r] <= in_y;
        seen_r <= seen_r + 2'd1;
      end else begin
        wx_r[0] <= wx_r[1]; wy_r[0] <= wy_r[1];
        wx_r[1] <= wx_r[2]; wy_r[1] <= wy_r[2];
        wx_r[2] <= in_x; wy_r[2] <= in_y;
      end
    end
  end

  // Restoring divider: t = (c*2^(T+1) + n) / (2n), two samples in turn.
  logic [7:0] den;
  logic [NW:0] trial;
  assign den = {n_r, 1'b0};
  assign trial = {1'b0, num_r} - ({1'b0, NW'(den)} << (TW - 1 - dcnt_r));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; ddone_r <= 1'b0; c_r <= '0; n_r <= 7'd1; tsel_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.load_seg) begin c_r <= '0; n_r <= n_clip; end
      else if (cmd.next_sample) c_r <= c_r + 7'd1;
      if (cmd.start_div) begin
        dbusy_r <= 1'b1; tsel_r <= 1'b0; dcnt_r <= '0; q_r <= '0;
        num_r <= (NW'(cmd.load_seg ? 7'd0 : c_r + 7'd1) << (T_FRAC_BITS + 1))
               + NW'(cmd.load_seg ? n_clip : n_r);
      end else if (dbusy_r) begin
        if (dcnt_r == 5'(TW - 1)) begin
          t_r[tsel_r] <= q_r | (trial[NW] ? '0 : TW'(1));
          dcnt_r <= '0; q_r <= '0;
          if (tsel_r) begin dbusy_r <= 1'b0; ddone_r <= 1'b1; end
          else begin
            tsel_r <= 1'b1;
            num_r <= (NW'(c_r + 7'd1) << (T_FRAC_BITS + 1)) + NW'(n_r);
          end
        end else begin
          if (!trial[NW]) begin
            num_r <= trial[NW-1:0];
            q_r <= q_r | (TW'(1) << (TW - 1 - dcnt_r));
          end
          dcnt_r <= dcnt_r + 5'd1;
        end
      end
    end
  end

  // Shared Horner unit: four coordinates, three steps each.
  logic signed [HW-1:0] mag, hmul;
  logic [HW+TW-1:0] prod;
  logic [HW-1:0] rnd;
  logic signed [HW-1:0] pt_mag;
  logic signed [HW-1:0] pt;
  assign mag = h_r[HW-1] ? -h_r : h_r;
  assign prod = (HW+TW)'(mag) * (HW+TW)'(t_r[pidx_r[1]]);
  assign rnd = HW'((prod + (HW+TW)'(1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
  assign hmul = h_r[HW-1] ? -$signed(rnd) : $signed(rnd);
  assign pt_mag = HW'(({1'b0, mag} + (HW+1)'(1 << (SH - 1))) >> SH);
  assign pt = h_r[HW-1] ? -pt_mag : pt_mag;

  always_ff @(posedge clk) begin
    logic signed [HW-1:0] sat;
    if (!rst_n) begin
      ebusy_r <= 1'b0; edone_r <= 1'b0;
    end else begin
      edone_r <= 1'b0;
      if (cmd.start_eval) begin
        ebusy_r <= 1'b1; pidx_r <= '0; k_r <= 2'd3;
        h_r <= HW'(a_r[0][3]) <<< T_FRAC_BITS;
      end else if (ebusy_r) begin
        if (k_r != 2'd0) begin
          h_r <= (HW'(a_r[pidx_r[0]][k_r - 2'd1]) <<< T_FRAC_BITS) + hmul;
          k_r <= k_r - 2'd1;
        end else begin
          if (pt > HW'((1 <<< (OUT_W - 1)) - 1)) sat = HW'((1 <<< (OUT_W - 1)) - 1);
          else if (pt < -HW'(1 <<< (OUT_W - 1))) sat = -HW'(1 <<< (OUT_W - 1));
          else sat = pt;
          res[pidx_r] <= OUT_W'(sat);
          res_last <= (c_r + 7'd1 == n_r);
          k_r <= 2'd3;
          pidx_r <= pidx_r + 2'd1;
          h_r <= HW'(a_r[~pidx_r[0]][3]) <<< T_FRAC_BITS;
          if (pidx_r == 2'd3) begin ebusy_r <= 1'b0; edone_r <= 1'b1; end
        end
      end
    end
  end

  assign sts.div_done = ddone_r;
  assign sts.eval_done = edone_r;
  assign sts.last_sample = (c_r + 7'd1 == n_r);
endmodule
`default_nettype wire

FILE: sv/catmull_rom_curve_tessellator.sv
// Top level of the Catmull-Rom curve tessellator.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
`default_nettype none
// Streams control vertices; each vertex that completes a segment, and each end
// word with two or more stored vertices, produces detail point-pair words
// (detail clipped to 1..64). Vertices that complete no segment are only stored.
// Per pair the controller runs a bit-serial divider for the two t values and
// then the shared Horner multiplier over four coordinates. Input is not taken
// while a segment is being produced; the output register frees the datapath
// once a word is taken.
module catmull_rom_curve_tessellator #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [crt_pkg::DETAIL_W-1:0] cfg_wdata,
  input  wire logic in_tvalid,
  output logic in_tready,
  // tdata: vertex_x [15:0], vertex_y [31:16]
  input  wire logic [31:0] in_tdata,
  // tuser: kind
  input  wire logic in_tuser,
  output logic out_tvalid,
  input  wire logic out_tready,
  // tdata: first_x, first_y, second_x, second_y (28 bits each, lowest first)
  output logic [111:0] out_tdata,
  output logic out_tlast
);
  import crt_pkg::*;
  logic [DETAIL_W-1:0] detail_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, out_load, in_fire, res_last;
  logic [1:0] seen;
  logic signed [OUT_W-1:0] res [4];

  always_ff @(posedge clk) begin
    if (!rst_n) detail_r <= DETAIL_RESET;
    else if (cfg_we) detail_r <= cfg_wdata;
  end

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  crt_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_kind(in_tuser), .seen,
    .out_free(!out_tvalid || out_tready), .sts, .cmd, .busy, .out_load
  );

  crt_datapath #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_fire, .in_kind(in_tuser),
    .in_x(COORD_WIDTH'(in_tdata[15:0])), .in_y(COORD_WIDTH'(in_tdata[31:16])),
    .detail(detail_r), .cmd, .sts, .seen, .res, .res_last
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (out_load) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= {res[3], res[2], res[1], res[0]};
      out_tlast <= res_last;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("input taken while busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid || out_tready)) else $error("output overwritten");
endmodule
`default_nettype wire
